// File: hw/rtl/assert_macros.svh
// assertion macros for the rtl files
// no dependencies; the checks fall away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PBA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PBA_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define PBA_ASSERT(lbl, clk, rst, prop, msg)
`define PBA_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// File: hw/rtl/pba_pkg.sv
// package for the page bitmap allocator: command and status codes, beat types
// no dependencies
package pba_pkg;

  localparam int PAGE_TOTAL_DEF = 32768;
  localparam int FIELD_SPAN     = 32'h8000;
  localparam int WORD_BITS      = 32;

  typedef enum logic [2:0] {
    CMD_MARK_USED    = 3'd0,
    CMD_MARK_FREE    = 3'd1,
    CMD_CHECK_FREE   = 3'd2,
    CMD_ALLOC_FIXED  = 3'd3,
    CMD_ALLOC_ALIGN  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [14:0] start_page;
    logic [15:0] page_count;
    logic [15:0] align_pages;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] result_page;
  } result_t;

endpackage

// File: hw/rtl/page_bitmap_allocator.sv
// page bitmap allocator: one used bit per page in a word-wide bitmap memory
// depends on pba_pkg and assert_macros.svh
//
//  channel   handshake          beat
//  request   start / busy       pba_pkg::request_t (command, range, alignment)
//  result    done (1 cycle)     pba_pkg::result_t (status, result page)
//
// after reset the bitmap is cleared one word a cycle (1024 words at 32768 pages),
// busy high throughout. rejected requests and empty fixed ranges answer in the next cycle.
// range walks read each bitmap word, then check it or modify and write it back; allocate
// reads the words once to check and again to mark. each aligned candidate is set up in
// S_TRY; each failed one, alignment nonzero, adds a remainder computation in S_DIV.
// done may not be stalled.
`include "assert_macros.svh"

module page_bitmap_allocator #(
  parameter int PAGE_TOTAL = pba_pkg::PAGE_TOTAL_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  pba_pkg::request_t  request,
  output logic               done,
  output pba_pkg::result_t   result
);

  localparam int WORD_COUNT = (PAGE_TOTAL + pba_pkg::WORD_BITS - 1) / pba_pkg::WORD_BITS;
  localparam int WW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int AW = $clog2(PAGE_TOTAL + 2 * pba_pkg::FIELD_SPAN + 1);
  localparam int CW = $clog2(AW + 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_TRY   = 6'b000100,
    S_RD    = 6'b001000,
    S_EVAL  = 6'b010000,
    S_DIV   = 6'b100000
  } state_t;

  state_t      state;
  logic [31:0] mem [WORD_COUNT];
  logic [31:0] rd_data;

  logic [2:0]    cmd;
  logic [15:0]   count;
  logic [15:0]   align;
  logic [AW-1:0] page_lo;
  logic [AW-1:0] test;
  logic [WW-1:0] cur_word;
  logic [WW-1:0] lo_word;
  logic [WW-1:0] last_word;
  logic [4:0]    lo_bit;
  logic [4:0]    hi_bit;
  logic          walk_check;
  logic          walk_used;
  logic [WW-1:0] clr_idx;
  logic [AW-1:0] u_hold;
  logic [AW-1:0] div_num;
  logic [15:0]   rem;
  logic [CW-1:0] div_cnt;

  logic [AW-1:0] rng_lo;
  logic [AW-1:0] rng_last;
  logic [15:0]   rng_count;
  logic [4:0]    lo_b;
  logic [4:0]    hi_b;
  logic [31:0]   mask;
  logic [31:0]   masked;
  logic [AW-1:0] u;
  logic [16:0]   rem_sh;
  logic [15:0]   rem_nx;
  logic          mem_we;
  logic          mem_re;
  logic [WW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  function automatic logic [4:0] first_set(input logic [31:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

  assign busy = (state != S_IDLE);

  // range setup, from the request or from the current aligned candidate
  always_comb begin
    rng_lo    = (state == S_TRY) ? test : AW'(request.start_page);
    rng_count = (state == S_TRY) ? count : request.page_count;
    rng_last  = rng_lo + AW'(rng_count) - AW'(1);
  end

  always_comb begin
    lo_b   = (cur_word == lo_word) ? lo_bit : 5'd0;
    hi_b   = (cur_word == last_word) ? hi_bit : 5'd31;
    mask   = ({32{1'b1}} << lo_b) & ({32{1'b1}} >> (5'd31 - hi_b));
    masked = rd_data & mask;
    u      = (AW'(cur_word) << 5) | AW'(first_set(masked));
  end

  always_comb begin
    rem_sh = {rem, div_num[AW-1]};
    rem_nx = (rem_sh >= {1'b0, align}) ? 16'(rem_sh - {1'b0, align}) : rem_sh[15:0];
  end

  always_comb begin
    mem_we    = (state == S_CLEAR) || ((state == S_EVAL) && !walk_check);
    mem_re    = (state == S_RD);
    mem_waddr = (state == S_CLEAR) ? clr_idx : cur_word;
    mem_wdata = (state == S_CLEAR) ? 32'd0 :
                (walk_used ? (rd_data | mask) : (rd_data & ~mask));
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[cur_word];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + WW'(1);
          if (clr_idx == WW'(WORD_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd        <= request.command;
            count      <= request.page_count;
            align      <= request.align_pages;
            page_lo    <= rng_lo;
            cur_word   <= WW'(rng_lo >> 5);
            lo_word    <= WW'(rng_lo >> 5);
            last_word  <= WW'(rng_last >> 5);
            lo_bit     <= rng_lo[4:0];
            hi_bit     <= rng_last[4:0];
            walk_check <= (request.command == pba_pkg::CMD_CHECK_FREE) ||
                          (request.command == pba_pkg::CMD_ALLOC_FIXED);
            walk_used  <= (request.command != pba_pkg::CMD_MARK_FREE);
            result.result_page <= request.start_page;
            case (request.command)
              pba_pkg::CMD_MARK_USED, pba_pkg::CMD_MARK_FREE,
              pba_pkg::CMD_CHECK_FREE, pba_pkg::CMD_ALLOC_FIXED: begin
                if (AW'(request.start_page) + AW'(request.page_count) > AW'(PAGE_TOTAL)) begin
                  done          <= 1'b1;
                  result.status <= pba_pkg::ST_RANGE;
                end else if (request.page_count == 16'd0) begin
                  done          <= 1'b1;
                  result.status <= pba_pkg::ST_OK;
                end else begin
                  state <= S_RD;
                end
              end
              pba_pkg::CMD_ALLOC_ALIGN: begin
                if (AW'(request.page_count) > AW'(PAGE_TOTAL)) begin
                  done               <= 1'b1;
                  result.status      <= pba_pkg::ST_RANGE;
                  result.result_page <= '0;
                end else begin
                  test  <= '0;
                  state <= S_TRY;
                end
              end
              default: begin
                done          <= 1'b1;
                result.status <= pba_pkg::ST_RANGE;
              end
            endcase
          end
        end
        S_TRY: begin
          page_lo    <= rng_lo;
          cur_word   <= WW'(rng_lo >> 5);
          lo_word    <= WW'(rng_lo >> 5);
          last_word  <= WW'(rng_last >> 5);
          lo_bit     <= rng_lo[4:0];
          hi_bit     <= rng_last[4:0];
          walk_check <= 1'b1;
          walk_used  <= 1'b1;
          if (test + AW'(count) > AW'(PAGE_TOTAL)) begin
            done               <= 1'b1;
            result.status      <= pba_pkg::ST_BUSY;
            result.result_page <= '0;
            state              <= S_IDLE;
          end else if (count == 16'd0) begin
            done               <= 1'b1;
            result.status      <= pba_pkg::ST_OK;
            result.result_page <= test[14:0];
            state              <= S_IDLE;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (walk_check) begin
            if (masked != 32'd0) begin
              if (cmd == pba_pkg::CMD_ALLOC_ALIGN) begin
                if (align == 16'd0) begin
                  done               <= 1'b1;
                  result.status      <= pba_pkg::ST_BUSY;
                  result.result_page <= '0;
                  state              <= S_IDLE;
                end else begin
                  u_hold  <= u;
                  div_num <= u;
                  rem     <= '0;
                  div_cnt <= CW'(AW);
                  state   <= S_DIV;
                end
              end else begin
                done               <= 1'b1;
                result.status      <= pba_pkg::ST_BUSY;
                result.result_page <= page_lo[14:0];
                state              <= S_IDLE;
              end
            end else if (cur_word == last_word) begin
              if (cmd == pba_pkg::CMD_CHECK_FREE) begin
                done               <= 1'b1;
                result.status      <= pba_pkg::ST_OK;
                result.result_page <= page_lo[14:0];
                state              <= S_IDLE;
              end else begin
                walk_check <= 1'b0;
                cur_word   <= lo_word;
                state      <= S_RD;
              end
            end else begin
              cur_word <= cur_word + WW'(1);
              state    <= S_RD;
            end
          end else begin
            if (cur_word == last_word) begin
              done               <= 1'b1;
              result.status      <= pba_pkg::ST_OK;
              result.result_page <= page_lo[14:0];
              state              <= S_IDLE;
            end else begin
              cur_word <= cur_word + WW'(1);
              state    <= S_RD;
            end
          end
        end
        S_DIV: begin
          // restoring remainder, one dividend bit a cycle
          if (div_cnt != '0) begin
            rem     <= rem_nx;
            div_num <= div_num << 1;
            div_cnt <= div_cnt - CW'(1);
          end else begin
            test  <= u_hold - AW'(rem) + AW'(align);
            state <= S_TRY;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PBA_ASSERT_NEVER(a_no_rw_clash, clk, rst, mem_we && mem_re, "read and write in one cycle")
  `PBA_ASSERT(a_walk_bound, clk, rst, (state == S_EVAL) |-> (cur_word <= last_word), "walk past range")
  `PBA_ASSERT(a_div_exit, clk, rst, (state == S_DIV) |=> (state == S_DIV || state == S_TRY), "divider exit")
  `PBA_ASSERT(a_status_code, clk, rst, done |-> (result.status <= pba_pkg::ST_RANGE), "bad status")
  `PBA_ASSERT(a_done_idle, clk, rst, done |-> !busy, "result while busy")

endmodule

// File: tb/page_bitmap_allocator_test.sv
`timescale 1ns / 1ps
// self-checking bench for page_bitmap_allocator: directed then random command beats,
// with a page map in the bench predicting every result; depends on pba_pkg and the rtl
module page_bitmap_allocator_test;
  import pba_pkg::*;

  localparam int PAGES = PAGE_TOTAL_DEF;
  localparam int WORDS = PAGES / WORD_BITS;
  localparam int RANDOM_BEATS = 500;
  localparam int IDLE_LIMIT = 5000000;
  localparam logic [2:0] CMD_RSVD_5 = 3'd5;
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  request_t request = '0;
  result_t result;

  bit [31:0] page_words [WORDS];
  request_t pending_requests [$];
  result_t expected_outcomes [$];
  result_t want;
  logic beat_taken = 1'b0;
  int idle_cycles = 0;
  int error_count = 0;
  int burst_left = 1;
  int gap_left = 0;

  page_bitmap_allocator dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic int first_used_page(int first, int count);
    int p;
    int stop;
    int hit;
    p = first;
    stop = first + count;
    hit = PAGES;
    while (p < stop && hit == PAGES) begin
      // whole free words are skipped
      if (p % WORD_BITS == 0 && stop - p >= WORD_BITS && page_words[p / WORD_BITS] == 0) begin
        p += WORD_BITS;
      end else begin
        if (page_words[p / WORD_BITS][p % WORD_BITS]) hit = p;
        p++;
      end
    end
    return hit;
  endfunction

  function automatic void fill_pages(int first, int count, bit val);
    for (int p = first; p < first + count; p++) page_words[p / WORD_BITS][p % WORD_BITS] = val;
  endfunction

  function automatic result_t predict_outcome(request_t rq);
    result_t res;
    int first;
    int count;
    int step;
    int cand;
    int hit;
    bit fits;
    bit searching;
    first = int'(rq.start_page);
    count = int'(rq.page_count);
    step = int'(rq.align_pages);
    fits = (first + count <= PAGES);
    res.status = ST_OK;
    res.result_page = rq.start_page;
    case (rq.command)
      CMD_MARK_USED, CMD_MARK_FREE: begin
        if (!fits) res.status = ST_RANGE;
        else fill_pages(first, count, rq.command == CMD_MARK_USED);
      end
      CMD_CHECK_FREE, CMD_ALLOC_FIXED: begin
        if (!fits) res.status = ST_RANGE;
        else if (first_used_page(first, count) < PAGES) res.status = ST_BUSY;
        else if (rq.command == CMD_ALLOC_FIXED) fill_pages(first, count, 1'b1);
      end
      CMD_ALLOC_ALIGN: begin
        res.result_page = '0;
        if (count > PAGES) begin
          res.status = ST_RANGE;
        end else begin
          res.status = ST_BUSY;
          cand = 0;
          searching = 1'b1;
          while (searching && cand + count <= PAGES) begin
            hit = first_used_page(cand, count);
            if (hit >= PAGES) begin
              res.status = ST_OK;
              res.result_page = cand[14:0];
              fill_pages(cand, count, 1'b1);
              searching = 1'b0;
            end else if (step == 0) begin
              searching = 1'b0;
            end else begin
              cand = (hit / step + 1) * step;
            end
          end
        end
      end
      default: res.status = ST_RANGE;
    endcase
    return res;
  endfunction

  task automatic queue_request(input logic [2:0] cmd, input int first, input int count,
                               input int step);
    request_t rq;
    rq.command = cmd;
    rq.start_page = first[14:0];
    rq.page_count = count[15:0];
    rq.align_pages = step[15:0];
    pending_requests.push_back(rq);
  endtask

  function automatic request_t random_request();
    request_t rq;
    int pick;
    int count;
    rq.start_page = 15'($urandom_range(0, PAGES - 1));
    pick = $urandom_range(0, 99);
    if (pick < 60) rq.align_pages = 16'd1 << $urandom_range(0, 10);
    else if (pick < 75) rq.align_pages = 16'($urandom_range(1, 100));
    else if (pick < 85) rq.align_pages = '0;
    else if (pick < 93) rq.align_pages = 16'($urandom_range(0, 16'hffff));
    else rq.align_pages = 16'd1 << $urandom_range(11, 15);
    pick = $urandom_range(0, 99);
    if (pick < 70) count = $urandom_range(1, 32);
    else if (pick < 95) count = $urandom_range(0, 256);
    else count = $urandom_range(0, 2048);
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      rq.command = CMD_MARK_USED;
    end else if (pick < 30) begin
      rq.command = CMD_MARK_FREE;
      if ($urandom_range(0, 4) == 0) count = $urandom_range(0, PAGES);
    end else if (pick < 46) begin
      rq.command = CMD_CHECK_FREE;
      if ($urandom_range(0, 4) == 0) count = $urandom_range(0, PAGES);
    end else if (pick < 66) begin
      rq.command = CMD_ALLOC_FIXED;
    end else if (pick < 90) begin
      rq.command = CMD_ALLOC_ALIGN;
    end else if (pick < 97) begin
      // counts past the page space
      rq.command = 3'(CMD_MARK_USED + $urandom_range(0, 4));
      count = $urandom_range(PAGES + 1, 16'hffff);
    end else begin
      rq.command = 3'(CMD_RSVD_5 + $urandom_range(0, 2));
    end
    rq.page_count = count[15:0];
    return rq;
  endfunction

  // sender: bursts with random gaps, beat held until taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        request <= pending_requests.pop_front();
        start <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // acceptance, prediction, result checking and watchdog
  always @(posedge clk) begin
    if (rst) begin
      beat_taken <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (done) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: status %0d page %0d",
                                    result.status, result.result_page));
        end else begin
          want = expected_outcomes.pop_front();
          if (result.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", result.status, want.status));
          if (result.result_page !== want.result_page)
            report_mismatch($sformatf("result_page %0d, expected %0d",
                                      result.result_page, want.result_page));
        end
      end
      if (start && !busy) expected_outcomes.push_back(predict_outcome(request));
      beat_taken <= start && !busy;
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    queue_request(CMD_CHECK_FREE, 0, PAGES, 0);
    queue_request(CMD_ALLOC_ALIGN, 0, 0, 0);
    queue_request(CMD_MARK_USED, PAGES - 1, 1, 0);
    queue_request(CMD_MARK_USED, PAGES - 1, 2, 0);
    queue_request(CMD_CHECK_FREE, PAGES - 8, 8, 0);
    queue_request(CMD_ALLOC_FIXED, PAGES - 8, 8, 0);
    queue_request(CMD_ALLOC_FIXED, 100, 40, 0);
    queue_request(CMD_ALLOC_ALIGN, 0, 10, 0);
    queue_request(CMD_ALLOC_ALIGN, 0, 10, 0);
    queue_request(CMD_ALLOC_ALIGN, 0, PAGES + 1, 1);
    queue_request(CMD_ALLOC_ALIGN, 0, 64, 64);
    queue_request(CMD_ALLOC_ALIGN, 0, PAGES, 1);
    queue_request(CMD_RSVD_5, PAGES - 1, 1, 1);
    queue_request(CMD_RSVD_6, 0, 0, 0);
    queue_request(CMD_RSVD_7, 16'h5555, 16'hffff, 16'hffff);
    queue_request(CMD_MARK_FREE, 0, PAGES, 0);
    queue_request(CMD_ALLOC_ALIGN, PAGES - 1, PAGES, 16'hffff);
    queue_request(CMD_CHECK_FREE, 0, 0, 0);
    queue_request(CMD_MARK_USED, PAGES - 1, 0, 0);
    queue_request(CMD_CHECK_FREE, PAGES - 1, 16'hffff, 0);
    queue_request(CMD_MARK_FREE, 0, PAGES, 0);
    queue_request(CMD_ALLOC_ALIGN, 0, 1, PAGES);
    queue_request(CMD_ALLOC_ALIGN, 0, 1, PAGES);
    queue_request(CMD_ALLOC_FIXED, 16'h5555, 16'h2aaa, 0);
    queue_request(CMD_MARK_FREE, 0, PAGES, 0);
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      // keep the map sparse so aligned searches stay short
      if (i % 40 == 39) queue_request(CMD_MARK_FREE, 0, PAGES, 0);
      else pending_requests.push_back(random_request());
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (pending_requests.size() != 0 || start) @(posedge clk);
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
